FILE: hw/rtl/ensr_pkg.sv
// Shared types and constants for the encoder speed unit.
// No dependencies; every other file refers to it by scoped names.
package ensr_pkg;

  // Field and register widths
  localparam int PPR_W       = 16;
  localparam int PERIOD_W    = 16;
  localparam int CNT_W       = 16;
  localparam int TIME_W      = 32;
  localparam int SPEED_W     = 32;
  localparam int SCALE_W     = 16;
  localparam int DIVISOR_W   = PPR_W + TIME_W;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  // Counts per revolution to RPM with millisecond time
  localparam logic [SCALE_W-1:0] RPM_SCALE = 16'd60000;

  // Command codes carried in tuser
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_REBASE  = 1'b1;

  // Register index, taken from address bit 2
  localparam logic REG_PPR    = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = '1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_LOAD
  } state_t;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: hw/rtl/ensr_cfg.sv
// Configuration register file behind an APB-style port.
// Depends on ensr_pkg for widths, register indexes and reset values.
module ensr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ensr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ensr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [ensr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [ensr_pkg::PPR_W-1:0]        ppr,
  output logic [ensr_pkg::PERIOD_W-1:0]     period
);

  logic [ensr_pkg::PPR_W-1:0]    ppr_r;
  logic [ensr_pkg::PERIOD_W-1:0] period_r;
  logic                          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r    <= '0;
      period_r <= ensr_pkg::PERIOD_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        ensr_pkg::REG_PPR:    ppr_r    <= pwdata[ensr_pkg::PPR_W-1:0];
        ensr_pkg::REG_PERIOD: period_r <= pwdata[ensr_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      ensr_pkg::REG_PPR:    prdata[ensr_pkg::PPR_W-1:0]    = ppr_r;
      ensr_pkg::REG_PERIOD: prdata[ensr_pkg::PERIOD_W-1:0] = period_r;
      default: ;
    endcase
  end

  assign ppr    = ppr_r;
  assign period = period_r;

endmodule

FILE: hw/rtl/ensr_mul.sv
// Bit-serial shift-and-add multiplier: counts per revolution times elapsed time.
// Depends on ensr_pkg; one multiplier bit per cycle.
module ensr_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ensr_pkg::PPR_W-1:0]       mplier,
  input  logic [ensr_pkg::TIME_W-1:0]      mcand,
  output logic [ensr_pkg::DIVISOR_W-1:0]   product,
  output ensr_pkg::unit_stat_t             stat
);

  localparam int STEP_W = $clog2(ensr_pkg::PPR_W + 1);
  localparam logic [STEP_W-1:0] STEPS    = STEP_W'(ensr_pkg::PPR_W);
  localparam logic [STEP_W-1:0] LAST_ONE = STEP_W'(1);

  logic [ensr_pkg::DIVISOR_W-1:0] acc_r, acc_nxt;
  logic [ensr_pkg::DIVISOR_W-1:0] mcand_r;
  logic [ensr_pkg::PPR_W-1:0]     mplier_r;
  logic [STEP_W-1:0]              step_r;
  logic                           done_r;
  logic                           busy;

  assign busy = (step_r != '0);

  // Add the shifted multiplicand when the current multiplier bit is set
  always_comb begin
    acc_nxt = acc_r;
    if (mplier_r[0]) begin
      acc_nxt = acc_r + mcand_r;
    end
  end

  // Step counter and completion flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy && (step_r == LAST_ONE);
      if (start) begin
        step_r <= STEPS;
      end else if (busy) begin
        step_r <= step_r - LAST_ONE;
      end
    end
  end

  // Shift the operands one bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= {{ensr_pkg::PPR_W{1'b0}}, mcand};
      mplier_r <= mplier;
    end else if (busy) begin
      acc_r    <= acc_nxt;
      mcand_r  <= {mcand_r[ensr_pkg::DIVISOR_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[ensr_pkg::PPR_W-1:1]};
    end
  end

  assign product   = acc_r;
  assign stat.busy = busy;
  assign stat.done = done_r;

endmodule

FILE: hw/rtl/ensr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ensr_pkg for the status struct.
module ensr_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_W-1:0]     numer,
  input  logic [DEN_W-1:0]     denom,
  output logic [NUM_W-1:0]     quotient,
  output ensr_pkg::unit_stat_t stat
);

  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam logic [STEP_W-1:0] STEPS    = STEP_W'(NUM_W);
  localparam logic [STEP_W-1:0] LAST_ONE = STEP_W'(1);

  logic [DEN_W-1:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0]   quo_r, quo_nxt;
  logic [DEN_W-1:0]   den_r;
  logic [STEP_W-1:0]  step_r;
  logic               done_r;
  logic               busy;
  logic [DEN_W:0]     shifted;
  logic [DEN_W+1:0]   trial;
  logic               fits;

  assign busy = (step_r != '0);

  // Bring down the next dividend bit and try the subtraction
  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den_r};
    fits    = !trial[DEN_W+1];
    rem_nxt = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], fits};
  end

  // Step counter and completion flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy && (step_r == LAST_ONE);
      if (start) begin
        step_r <= STEPS;
      end else if (busy) begin
        step_r <= step_r - LAST_ONE;
      end
    end
  end

  // Dividend shifts out of the top as quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= numer;
      den_r <= denom;
    end else if (busy) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy;
  assign stat.done = done_r;

endmodule

FILE: hw/rtl/encoder_speed_rpm_unit.sv
// Encoder speed unit: encoder count and millisecond timestamp in, RPM out.
// Depends on ensr_pkg, ensr_cfg, ensr_mul and ensr_div.
//
// Input stream: in_tuser is the command (measure or rebase), in_tdata holds
// the counter sample and the timestamp. Output stream: one speed item per
// input item, in order. Registers pulses_per_rev (0x0) and counter_period
// (0x4) are written over the cfg_ APB port; the user must write them only
// while the unit is idle, as the unit itself does not enforce this.
// A rebase item, a measure with pulses_per_rev zero or with no elapsed time
// gives 0 and passes from idle straight to the load state, then to the output.
// A measure item runs a 16-step serial multiplier (pulses times elapsed
// time) and then a (COUNT_BITS + 16)-step restoring divider, and its result
// passes through the load state into the output register; the unit takes
// the next item once it is back in idle.
// One item is in work at a time; in_tready is high only when idle.
// The output register holds one finished item; the unit takes the next input
// while it waits. If the receiver still stalls when the next result is
// ready, that result waits inside and in_tready stays low.
// Synchronous reset clears the stored sample to count 0 at time 0, sets
// pulses_per_rev to 0 and counter_period to 65535, and empties the output.
module encoder_speed_rpm_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [47:0]                       in_tdata,  // [15:0] count_sample, [47:16] time_ms
  input  logic                              in_tuser,  // [0] cmd
  // Result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata, // [31:0] speed_rpm
  // Configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ensr_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [ensr_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [ensr_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int NUM_W = COUNT_BITS + ensr_pkg::SCALE_W;

  ensr_pkg::state_t state_r, state_nxt;

  logic [ensr_pkg::PPR_W-1:0]     ppr;
  logic [ensr_pkg::PERIOD_W-1:0]  period;

  logic [COUNT_BITS-1:0]          prev_count_r;
  logic [ensr_pkg::TIME_W-1:0]    prev_time_r;
  logic [COUNT_BITS-1:0]          delta_r;
  logic [ensr_pkg::SPEED_W-1:0]   res_r;
  logic                           out_valid_r;
  logic [ensr_pkg::SPEED_W-1:0]   out_data_r;

  logic                           accept;
  logic                           cmd;
  logic [ensr_pkg::TIME_W-1:0]    now_time;
  logic [COUNT_BITS+ensr_pkg::CNT_W-1:0] cnt_ext;
  logic [COUNT_BITS-1:0]          now_cnt;
  logic [ensr_pkg::TIME_W-1:0]    dt;
  logic [ensr_pkg::PERIOD_W:0]    wrap17;
  logic [COUNT_BITS+ensr_pkg::PERIOD_W:0] wrap_ext;
  logic [COUNT_BITS-1:0]          wrap_c;
  logic [COUNT_BITS-1:0]          delta_c;
  logic                           quick;
  logic [NUM_W-1:0]               numer;
  logic [NUM_W+ensr_pkg::SPEED_W-1:0] quo_ext;

  logic                           out_free;
  logic                           ready_c;
  logic                           mul_start;
  logic                           div_start;
  logic                           div_take;
  logic                           out_load;

  logic [ensr_pkg::DIVISOR_W-1:0] product;
  logic [NUM_W-1:0]               quotient;
  ensr_pkg::unit_stat_t           mul_stat;
  ensr_pkg::unit_stat_t           div_stat;

  // Configuration registers
  ensr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .ppr     (ppr),
    .period  (period)
  );

  // Unpack the item and form elapsed time and count change
  always_comb begin
    cmd      = in_tuser;
    now_time = in_tdata[47:16];
    cnt_ext  = {{COUNT_BITS{1'b0}}, in_tdata[ensr_pkg::CNT_W-1:0]};
    now_cnt  = cnt_ext[COUNT_BITS-1:0];
    dt       = now_time - prev_time_r;
    wrap17   = {1'b0, period} + {{ensr_pkg::PERIOD_W{1'b0}}, 1'b1};
    wrap_ext = {{COUNT_BITS{1'b0}}, wrap17};
    wrap_c   = wrap_ext[COUNT_BITS-1:0];
    if (now_cnt >= prev_count_r) begin
      delta_c = now_cnt - prev_count_r;
    end else begin
      delta_c = wrap_c - prev_count_r + now_cnt;
    end
    quick = (cmd == ensr_pkg::CMD_REBASE) || (ppr == '0) || (dt == '0);
  end

  assign accept   = in_tvalid && ready_c;
  assign out_free = !out_valid_r || out_tready;

  // Scale the count change by 60000 ms per minute
  assign numer   = {{ensr_pkg::SCALE_W{1'b0}}, delta_r}
                 * {{COUNT_BITS{1'b0}}, ensr_pkg::RPM_SCALE};
  assign quo_ext = {{ensr_pkg::SPEED_W{1'b0}}, quotient};

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ensr_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = quick ? ensr_pkg::ST_LOAD : ensr_pkg::ST_MUL;
        end
      end
      ensr_pkg::ST_MUL: begin
        if (mul_stat.done) state_nxt = ensr_pkg::ST_DIV;
      end
      ensr_pkg::ST_DIV: begin
        if (div_stat.done) state_nxt = ensr_pkg::ST_LOAD;
      end
      ensr_pkg::ST_LOAD: begin
        if (out_free) state_nxt = ensr_pkg::ST_IDLE;
      end
      default: state_nxt = ensr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    ready_c   = 1'b0;
    div_start = 1'b0;
    div_take  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ensr_pkg::ST_IDLE: ready_c   = 1'b1;
      ensr_pkg::ST_MUL:  div_start = mul_stat.done;
      ensr_pkg::ST_DIV:  div_take  = div_stat.done;
      ensr_pkg::ST_LOAD: out_load  = out_free;
      default: ;
    endcase
  end

  assign mul_start = accept && !quick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ensr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Stored sample: rebase zeroes the count, a measure stores unless ppr is zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_count_r <= '0;
      prev_time_r  <= '0;
    end else if (accept) begin
      if (cmd == ensr_pkg::CMD_REBASE) begin
        prev_count_r <= '0;
        prev_time_r  <= now_time;
      end else if (ppr != '0) begin
        prev_count_r <= now_cnt;
        prev_time_r  <= now_time;
      end
    end
  end

  // Hold the count change and the pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      delta_r <= delta_c;
      res_r   <= '0;
    end else if (div_take) begin
      res_r   <= quo_ext[ensr_pkg::SPEED_W-1:0];
    end
  end

  ensr_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mplier  (ppr),
    .mcand   (dt),
    .product (product),
    .stat    (mul_stat)
  );

  ensr_div #(
    .NUM_W (NUM_W),
    .DEN_W (ensr_pkg::DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .numer    (numer),
    .denom    (product),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Output register: load a finished item, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign in_tready  = ready_c;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Arithmetic units stay quiet while the sequencer waits for an item
  a_idle_units_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ensr_pkg::ST_IDLE) |-> (!mul_stat.busy && !div_stat.busy))
    else $error("arithmetic unit busy while idle");

  // Divider completion only while the sequencer waits for it
  a_div_done_in_div : assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ensr_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  // Only one item in work at a time
  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while another is in work");

  // A measure with zero pulses per revolution yields zero at once
  a_zero_ppr_result : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == ensr_pkg::CMD_MEASURE) && (ppr == '0))
    |=> ((state_r == ensr_pkg::ST_LOAD) && (res_r == '0)))
    else $error("zero pulses per revolution did not give zero");

endmodule
